### rtl/core/hpds_pkg.sv
`default_nettype none

package hpds_pkg;

   localparam int TICKS_PER_MINUTE = 60000;
   localparam int HOLD_MINUTES     = 5;

   localparam int ELAPSED_W = 16;
   localparam int TEMP_W    = 12;
   localparam int MIN_W     = 8;
   localparam int TPM_W     = 16;
   localparam int PROD_W    = MIN_W + TPM_W;
   localparam int CD_W      = 25;
   localparam int CODE_W    = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 12;

   localparam logic [CD_W-1:0] HOLD_MS = CD_W'(HOLD_MINUTES * TICKS_PER_MINUTE);

   // phase codes as seen on the result channel
   localparam logic [CODE_W-1:0] PH_CODE_START   = 2'd0;
   localparam logic [CODE_W-1:0] PH_CODE_HEAT    = 2'd1;
   localparam logic [CODE_W-1:0] PH_CODE_DEFROST = 2'd2;
   localparam logic [CODE_W-1:0] PH_CODE_ERROR   = 2'd3;

   typedef enum logic [3:0] {
      ST_START   = 4'b0001,
      ST_HEAT    = 4'b0010,
      ST_DEFROST = 4'b0100,
      ST_ERROR   = 4'b1000
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLD_LIMIT    = 4'd0,
      REG_MID_LIMIT     = 4'd1,
      REG_THAW_LIMIT    = 4'd2,
      REG_START_LIMIT   = 4'd3,
      REG_HEAT_MIN      = 4'd4,
      REG_DEF_LONG_MIN  = 4'd5,
      REG_DEF_MID_MIN   = 4'd6,
      REG_DEF_SHORT_MIN = 4'd7
   } csr_index_type;

   function automatic logic [CODE_W-1:0] phase_code(input phase_type ph);
      logic [CODE_W-1:0] code;
      unique case (ph)
         ST_START:   code = PH_CODE_START;
         ST_HEAT:    code = PH_CODE_HEAT;
         ST_DEFROST: code = PH_CODE_DEFROST;
         ST_ERROR:   code = PH_CODE_ERROR;
         default:    code = PH_CODE_START;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### rtl/core/hpds_req_if.sv
`default_nettype none

interface hpds_req_if
   import hpds_pkg::*;
;
   logic                        valid;
   logic                        ready;
   logic        [ELAPSED_W-1:0] elapsed_ms;
   logic signed [TEMP_W-1:0]    coil_temp;
   logic                        sensor_fault;

   modport source (output valid, elapsed_ms, coil_temp, sensor_fault, input ready);
   modport sink   (input valid, elapsed_ms, coil_temp, sensor_fault, output ready);
endinterface

`default_nettype wire

### rtl/core/hpds_rsp_if.sv
`default_nettype none

interface hpds_rsp_if
   import hpds_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic        [CODE_W-1:0] phase;
   logic        [CODE_W-1:0] following_phase;
   logic signed [CD_W-1:0]   time_left;
   logic                     pump_drive;
   logic                     phase_changed;

   modport source (output valid, phase, following_phase, time_left, pump_drive,
                   phase_changed, input ready);
   modport sink   (input valid, phase, following_phase, time_left, pump_drive,
                   phase_changed, output ready);
endinterface

`default_nettype wire

### rtl/core/hpds_csr_if.sv
`default_nettype none

interface hpds_csr_if
   import hpds_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/heat_pump_defrost_sequencer_top.sv
`default_nettype none

// Heat pump defrost sequencer. Each request is one tick (elapsed ms, coil
// temperature, sensor fault) and yields exactly one response with the phase,
// following phase, signed countdown, pump drive and a phase-changed flag.
// A request is registered in the request register on acceptance, and the whole
// tick update runs in one pass of logic into the response register; a new
// request is taken every clock unless the consumer stalls, and the request
// register holds one extra request while the consumer stalls.
// Settings registers (indexes 0..7, higher indexes ignored) take effect at once
// and are to be written while no request is in flight. After reset the start
// phase entry is evaluated with the first request's temperature.
module heat_pump_defrost_sequencer_top
   import hpds_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   hpds_req_if.sink   req_if,
   hpds_rsp_if.source rsp_if,
   hpds_csr_if.sink   csr_if
);

   // settings
   logic signed [TEMP_W-1:0] cold_limit_ff, mid_limit_ff, thaw_limit_ff, start_limit_ff;
   logic [MIN_W-1:0]         heat_min_ff, def_long_min_ff, def_mid_min_ff, def_short_min_ff;

   // tick state
   phase_type              phase_ff, phase_in;
   phase_type              following_ff, following_in;
   logic signed [CD_W-1:0] countdown_ff, countdown_in;
   logic                   pending_ff;

   // request register
   logic                     s1_valid_ff;
   logic [ELAPSED_W-1:0]     s1_elapsed_ff;
   logic signed [TEMP_W-1:0] s1_temp_ff;
   logic                     s1_fault_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [CODE_W-1:0]        rsp_phase_ff, rsp_following_ff;
   logic signed [CD_W-1:0]   rsp_time_ff;
   logic                     rsp_pump_ff, rsp_changed_ff;

   logic advance;
   logic req_take;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign req_take = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cold_limit_ff    <= -12'sd128;
         mid_limit_ff     <= -12'sd96;
         thaw_limit_ff    <= -12'sd32;
         start_limit_ff   <= 12'sd0;
         heat_min_ff      <= 8'd50;
         def_long_min_ff  <= 8'd30;
         def_mid_min_ff   <= 8'd20;
         def_short_min_ff <= 8'd10;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            REG_COLD_LIMIT:    cold_limit_ff    <= signed'(csr_if.data);
            REG_MID_LIMIT:     mid_limit_ff     <= signed'(csr_if.data);
            REG_THAW_LIMIT:    thaw_limit_ff    <= signed'(csr_if.data);
            REG_START_LIMIT:   start_limit_ff   <= signed'(csr_if.data);
            REG_HEAT_MIN:      heat_min_ff      <= csr_if.data[MIN_W-1:0];
            REG_DEF_LONG_MIN:  def_long_min_ff  <= csr_if.data[MIN_W-1:0];
            REG_DEF_MID_MIN:   def_mid_min_ff   <= csr_if.data[MIN_W-1:0];
            REG_DEF_SHORT_MIN: def_short_min_ff <= csr_if.data[MIN_W-1:0];
            default: ;
         endcase
      end
   end

   // tick update
   phase_type              phase1, phase2, final_ph, fol1, start_fol;
   logic signed [CD_W-1:0] cd1, dec, cd2;
   logic                   cd_pos, expired, heat_cold, late_entry, any_entry;
   logic                   warm;
   logic [MIN_W-1:0]       mins;
   logic [PROD_W-1:0]      prod;

   always_comb begin
      warm      = s1_temp_ff > thaw_limit_ff;
      start_fol = (s1_temp_ff < start_limit_ff) ? ST_DEFROST : ST_HEAT;

      phase1 = pending_ff ? ST_START  : phase_ff;
      fol1   = pending_ff ? start_fol : following_ff;
      cd1    = pending_ff ? signed'(HOLD_MS) : countdown_ff;

      cd_pos  = cd1 > 0;
      dec     = cd1 - signed'(CD_W'(s1_elapsed_ff));
      expired = cd_pos && (dec <= 0);
      cd2     = cd_pos ? dec : cd1;

      phase2 = phase1;
      if (expired) begin
         phase2 = (fol1 == ST_DEFROST && warm) ? ST_HEAT : fol1;
      end

      heat_cold = !s1_fault_ff && phase2 == ST_HEAT && s1_temp_ff < cold_limit_ff;

      priority if (s1_fault_ff) begin
         final_ph = ST_ERROR;
      end else if (heat_cold) begin
         final_ph = warm ? ST_HEAT : ST_DEFROST;
      end else begin
         final_ph = phase2;
      end

      late_entry = expired || s1_fault_ff || heat_cold;
      any_entry  = late_entry || pending_ff;

      unique case (final_ph)
         ST_START: begin
            following_in = start_fol;
            mins         = MIN_W'(HOLD_MINUTES);
         end
         ST_HEAT: begin
            following_in = ST_DEFROST;
            mins         = heat_min_ff;
         end
         ST_DEFROST: begin
            following_in = ST_HEAT;
            priority if (s1_temp_ff < cold_limit_ff) begin
               mins = def_long_min_ff;
            end else if (s1_temp_ff < mid_limit_ff) begin
               mins = def_mid_min_ff;
            end else begin
               mins = def_short_min_ff;
            end
         end
         ST_ERROR: begin
            following_in = ST_START;
            mins         = MIN_W'(HOLD_MINUTES);
         end
         default: begin
            following_in = ST_START;
            mins         = MIN_W'(HOLD_MINUTES);
         end
      endcase

      prod = PROD_W'(mins) * PROD_W'(TICKS_PER_MINUTE);

      if (!any_entry) begin
         following_in = following_ff;
      end
      countdown_in = late_entry ? signed'(CD_W'(prod)) : cd2;
      phase_in     = final_ph;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= ST_START;
         following_ff <= ST_HEAT;
         countdown_ff <= signed'(HOLD_MS);
         pending_ff   <= 1'b1;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            following_ff <= following_in;
            countdown_ff <= countdown_in;
            pending_ff   <= 1'b0;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_elapsed_ff <= req_if.elapsed_ms;
         s1_temp_ff    <= req_if.coil_temp;
         s1_fault_ff   <= req_if.sensor_fault;
      end
      if (advance) begin
         rsp_phase_ff     <= phase_code(phase_in);
         rsp_following_ff <= phase_code(following_in);
         rsp_time_ff      <= countdown_in;
         rsp_pump_ff      <= (phase_in == ST_HEAT);
         rsp_changed_ff   <= (phase_in != phase_ff);
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.phase           = rsp_phase_ff;
   assign rsp_if.following_phase = rsp_following_ff;
   assign rsp_if.time_left       = rsp_time_ff;
   assign rsp_if.pump_drive      = rsp_pump_ff;
   assign rsp_if.phase_changed   = rsp_changed_ff;

endmodule

`default_nettype wire

### rtl/core/hpds_checker.sv
`default_nettype none

module hpds_checker
   import hpds_pkg::*;
(
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire        [CODE_W-1:0] rsp_phase,
   input wire        [CODE_W-1:0] rsp_following,
   input wire signed [CD_W-1:0]   rsp_time_left,
   input wire                     rsp_pump
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_following) && $stable(rsp_time_left) && $stable(rsp_pump))
      else $error("stalled response changed");

   a_pump_heat_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pump == (rsp_phase == PH_CODE_HEAT))
      else $error("pump drive does not match heat phase");

   a_error_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_CODE_ERROR |-> rsp_following == PH_CODE_START)
      else $error("error phase not followed by start");

   a_heat_follows_defrost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_CODE_HEAT |-> rsp_following == PH_CODE_DEFROST)
      else $error("heat phase not followed by defrost");

endmodule

bind heat_pump_defrost_sequencer_top hpds_checker u_hpds_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_phase     (rsp_if.phase),
   .rsp_following (rsp_if.following_phase),
   .rsp_time_left (rsp_if.time_left),
   .rsp_pump      (rsp_if.pump_drive)
);

`default_nettype wire
